/* hw/rtl/mctt_pkg.sv */
// Shared types and constants for the MIDI clock tempo tracker.
`default_nettype none
package mctt_pkg;

    localparam int AVG_WINDOW_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;

    localparam int IN_W    = 72;
    localparam int OUT_W   = 24;
    localparam int TIME_W  = 49;
    localparam int RATE_W  = 20;
    localparam int JIT_W   = 12;
    localparam int TEMPO_W = 18;
    localparam int DT_W    = 32;

    localparam logic [RATE_W-1:0]  SAMPLE_RATE_RESET = 20'd48000;
    localparam logic [JIT_W-1:0]   JITTER_RESET      = 12'd512;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET_Q8    = 18'd30720;
    localparam logic [TEMPO_W-1:0] TEMPO_MIN_Q8      = 18'd2560;
    localparam logic [TEMPO_W-1:0] TEMPO_MAX_Q8      = 18'd255744;

    localparam logic CFG_SAMPLE_RATE = 1'b0;
    localparam logic CFG_JITTER      = 1'b1;

    typedef enum logic [2:0] {
        OP_OTHER = 3'd0,
        OP_CLOCK = 3'd1,
        OP_START = 3'd2,
        OP_CONT  = 3'd3,
        OP_STOP  = 3'd4
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [TIME_W-1:0] now;
    } q_entry_t;

endpackage
`default_nettype wire

/* hw/rtl/mctt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mctt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                               clk,
    input  wire logic                               wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]           wr_addr,
    input  wire logic [WIDTH-1:0]                   wr_data,
    input  wire logic                               rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]           rd_addr,
    output logic      [WIDTH-1:0]                   rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/mctt_front.sv */
// Input stage: sample time sum, status classification and item queue.
`default_nettype none
module mctt_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mctt_pkg::IN_W-1:0]     s_tdata,
    output logic                               q_valid,
    input  wire logic                          q_pop,
    output mctt_pkg::q_entry_t                 q_entry
);

    localparam logic [7:0] ST_CLOCK = 8'hF8;
    localparam logic [7:0] ST_START = 8'hFA;
    localparam logic [7:0] ST_CONT  = 8'hFB;
    localparam logic [7:0] ST_STOP  = 8'hFC;
    localparam int PTR_W = $clog2(mctt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mctt_pkg::QUEUE_DEPTH + 1);

    mctt_pkg::q_entry_t queue_reg [mctt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    mctt_pkg::q_entry_t entry_in;
    logic               push;
    logic               pop;

    always_comb
    begin
        entry_in.now = mctt_pkg::TIME_W'(s_tdata[55:8]) + mctt_pkg::TIME_W'(s_tdata[71:56]);
        case (s_tdata[7:0])
            ST_CLOCK: entry_in.op = mctt_pkg::OP_CLOCK;
            ST_START: entry_in.op = mctt_pkg::OP_START;
            ST_CONT:  entry_in.op = mctt_pkg::OP_CONT;
            ST_STOP:  entry_in.op = mctt_pkg::OP_STOP;
            default:  entry_in.op = mctt_pkg::OP_OTHER;
        endcase
    end

    assign s_tready = (count_reg != CNT_W'(mctt_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_entry  = queue_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry_in;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(mctt_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");
`endif

endmodule
`default_nettype wire

/* hw/rtl/mctt_back.sv */
// Execution stage: transport state, interval window, jitter test and tempo divider.
`default_nettype none
module mctt_back #(
    parameter int AVG_WINDOW = mctt_pkg::AVG_WINDOW_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic                           cfg_index,
    input  wire logic [mctt_pkg::RATE_W-1:0]    cfg_data,
    input  wire logic                           q_valid,
    output logic                                q_pop,
    input  wire mctt_pkg::q_entry_t             q_entry,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [mctt_pkg::OUT_W-1:0]     m_tdata
);

    localparam int FILL_W = $clog2(AVG_WINDOW + 1);
    localparam int SLOT_W = $clog2(AVG_WINDOW);
    localparam int SUM_W  = mctt_pkg::DT_W + FILL_W;
    localparam int LHS_W  = mctt_pkg::DT_W + FILL_W;
    localparam int FS_W   = mctt_pkg::JIT_W + SUM_W;
    localparam int LF_W   = LHS_W + mctt_pkg::JIT_W;
    localparam int RF_W   = mctt_pkg::RATE_W + FILL_W;
    localparam int NUM_W  = RF_W + 10;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int TW     = mctt_pkg::TIME_W;
    localparam int PAD_W  = mctt_pkg::OUT_W - mctt_pkg::TEMPO_W - 2;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DT    = 10'b0000000010,
        S_MUL1  = 10'b0000000100,
        S_MUL2  = 10'b0000001000,
        S_CHK   = 10'b0000010000,
        S_UPD   = 10'b0000100000,
        S_RF    = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_CLAMP = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [mctt_pkg::RATE_W-1:0]     rate_reg, rate_next;
    logic [mctt_pkg::JIT_W-1:0]      jit_reg, jit_next;
    logic                            running_reg, running_next;
    logic [mctt_pkg::TEMPO_W-1:0]    tempo_reg, tempo_next;
    logic [SUM_W-1:0]                sum_reg, sum_next;
    logic [SLOT_W-1:0]               slot_reg, slot_next;
    logic [FILL_W-1:0]               fill_reg, fill_next;
    logic [TW-1:0]                   last_reg, last_next;
    logic                            last_valid_reg, last_valid_next;
    logic                            updated_reg, updated_next;
    mctt_pkg::op_t                   op_reg, op_next;
    logic [TW-1:0]                   now_reg, now_next;
    logic [mctt_pkg::DT_W-1:0]       dt_reg, dt_next;
    logic [LHS_W-1:0]                lhs_reg, lhs_next;
    logic [FS_W-1:0]                 fsum_reg, fsum_next;
    logic [LF_W-1:0]                 lhsf_reg, lhsf_next;
    logic                            rej_hi_reg, rej_hi_next;
    logic [RF_W-1:0]                 rf_reg, rf_next;
    logic                            rf_ok_reg, rf_ok_next;
    logic [NUM_W-1:0]                num_reg, num_next;
    logic [NUM_W-1:0]                quo_reg, quo_next;
    logic [SUM_W-1:0]                rem_reg, rem_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            out_run_reg, out_run_next;
    logic [mctt_pkg::TEMPO_W-1:0]    out_tempo_reg, out_tempo_next;
    logic                            out_upd_reg, out_upd_next;

    logic [TW-1:0]                   diff;
    logic [SUM_W:0]                  trial;
    logic                            trial_ge;
    logic                            chk_en;
    logic                            reject;
    logic                            out_free;
    logic                            ram_wr_en;
    logic                            ram_rd_en;
    logic [mctt_pkg::DT_W-1:0]       ram_rd_data;

    mctt_ram #(
        .WIDTH (mctt_pkg::DT_W),
        .DEPTH (AVG_WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (dt_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (slot_reg),
        .rd_data (ram_rd_data)
    );

    assign diff     = now_reg - last_reg;
    assign trial    = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ge = (trial >= {1'b0, sum_reg});
    assign chk_en   = (fill_reg >= FILL_W'(AVG_WINDOW / 2)) && (sum_reg != '0);
    assign reject   = chk_en && (rej_hi_reg ||
                      (lhsf_reg < LF_W'({sum_reg, 8'b0})));
    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign ram_rd_en = (state_reg == S_CHK);
    assign ram_wr_en = (state_reg == S_UPD);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_upd_reg, out_tempo_reg, out_run_reg};

    always_comb
    begin
        state_next      = state_reg;
        rate_next       = rate_reg;
        jit_next        = jit_reg;
        running_next    = running_reg;
        tempo_next      = tempo_reg;
        sum_next        = sum_reg;
        slot_next       = slot_reg;
        fill_next       = fill_reg;
        last_next       = last_reg;
        last_valid_next = last_valid_reg;
        updated_next    = updated_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        dt_next         = dt_reg;
        lhs_next        = lhs_reg;
        fsum_next       = fsum_reg;
        lhsf_next       = lhsf_reg;
        rej_hi_next     = rej_hi_reg;
        rf_next         = rf_reg;
        rf_ok_next      = rf_ok_reg;
        num_next        = num_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_run_next    = out_run_reg;
        out_tempo_next  = out_tempo_reg;
        out_upd_next    = out_upd_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                mctt_pkg::CFG_SAMPLE_RATE: rate_next = cfg_data;
                mctt_pkg::CFG_JITTER:      jit_next  = cfg_data[mctt_pkg::JIT_W-1:0];
                default:                   rate_next = rate_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    op_next    = q_entry.op;
                    now_next   = q_entry.now;
                    state_next = S_DT;
                end
            end
            S_DT:
            begin
                updated_next = 1'b0;
                state_next   = S_DONE;
                case (op_reg)
                    mctt_pkg::OP_CLOCK:
                    begin
                        if (last_valid_reg && (now_reg > last_reg))
                        begin
                            dt_next    = (|diff[TW-1:mctt_pkg::DT_W]) ? '1
                                         : diff[mctt_pkg::DT_W-1:0];
                            state_next = S_MUL1;
                        end
                        last_next       = now_reg;
                        last_valid_next = 1'b1;
                    end
                    mctt_pkg::OP_START:
                    begin
                        running_next    = 1'b1;
                        slot_next       = '0;
                        fill_next       = '0;
                        sum_next        = '0;
                        last_valid_next = 1'b0;
                    end
                    mctt_pkg::OP_CONT: running_next = 1'b1;
                    mctt_pkg::OP_STOP: running_next = 1'b0;
                    default:           running_next = running_reg;
                endcase
            end
            S_MUL1:
            begin
                lhs_next   = LHS_W'(dt_reg) * LHS_W'(fill_reg);
                fsum_next  = FS_W'(jit_reg) * FS_W'(sum_reg);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                lhsf_next   = LF_W'(lhs_reg) * LF_W'(jit_reg);
                rej_hi_next = (FS_W'({lhs_reg, 8'b0}) > fsum_reg);
                state_next  = S_CHK;
            end
            S_CHK:
            begin
                state_next = reject ? S_DONE : S_UPD;
            end
            S_UPD:
            begin
                if (fill_reg == FILL_W'(AVG_WINDOW))
                begin
                    sum_next = sum_reg - SUM_W'(ram_rd_data) + SUM_W'(dt_reg);
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                    sum_next  = sum_reg + SUM_W'(dt_reg);
                end
                slot_next  = (slot_reg == SLOT_W'(AVG_WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                state_next = S_RF;
            end
            S_RF:
            begin
                rf_next    = RF_W'(rate_reg) * RF_W'(fill_reg);
                rf_ok_next = (rate_reg != '0) && (sum_reg != '0);
                state_next = S_CLAMP;
                if ((rate_reg != '0) && (sum_reg != '0))
                begin
                    state_next = S_DIV;
                    cnt_next   = '0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    num_next = NUM_W'({rf_reg, 9'b0}) + NUM_W'({rf_reg, 7'b0});
                    rem_next = '0;
                    quo_next = '0;
                    cnt_next = CNT_W'(NUM_W);
                end
                else
                begin
                    rem_next = trial_ge ? SUM_W'(trial - {1'b0, sum_reg})
                               : trial[SUM_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], trial_ge};
                    num_next = {num_reg[NUM_W-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = S_CLAMP;
                    end
                end
            end
            S_CLAMP:
            begin
                if (quo_reg < NUM_W'(mctt_pkg::TEMPO_MIN_Q8))
                begin
                    tempo_next = mctt_pkg::TEMPO_MIN_Q8;
                end
                else if (quo_reg > NUM_W'(mctt_pkg::TEMPO_MAX_Q8))
                begin
                    tempo_next = mctt_pkg::TEMPO_MAX_Q8;
                end
                else
                begin
                    tempo_next = quo_reg[mctt_pkg::TEMPO_W-1:0];
                end
                updated_next = rf_ok_reg;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_run_next   = running_reg;
                    out_tempo_next = tempo_reg;
                    out_upd_next   = updated_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rate_reg       <= mctt_pkg::SAMPLE_RATE_RESET;
            jit_reg        <= mctt_pkg::JITTER_RESET;
            running_reg    <= 1'b0;
            tempo_reg      <= mctt_pkg::TEMPO_RESET_Q8;
            sum_reg        <= '0;
            slot_reg       <= '0;
            fill_reg       <= '0;
            last_reg       <= '0;
            last_valid_reg <= 1'b0;
            updated_reg    <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rate_reg       <= rate_next;
            jit_reg        <= jit_next;
            running_reg    <= running_next;
            tempo_reg      <= tempo_next;
            sum_reg        <= sum_next;
            slot_reg       <= slot_next;
            fill_reg       <= fill_next;
            last_reg       <= last_next;
            last_valid_reg <= last_valid_next;
            updated_reg    <= updated_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        now_reg       <= now_next;
        dt_reg        <= dt_next;
        lhs_reg       <= lhs_next;
        fsum_reg      <= fsum_next;
        lhsf_reg      <= lhsf_next;
        rej_hi_reg    <= rej_hi_next;
        rf_reg        <= rf_next;
        rf_ok_reg     <= rf_ok_next;
        num_reg       <= num_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        out_run_reg   <= out_run_next;
        out_tempo_reg <= out_tempo_next;
        out_upd_reg   <= out_upd_next;
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(AVG_WINDOW))
        else $error("fill count above window");

    a_sum_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) == (sum_reg == '0))
        else $error("interval sum disagrees with fill count");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (sum_reg != '0))
        else $error("divider running with zero divisor");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && out_free |=> out_valid_reg)
        else $error("result not loaded into output register");
`endif

endmodule
`default_nettype wire

/* hw/rtl/midi_clock_tempo_tracker_unit.sv */
// Path: a clock byte that updates the tempo passes S_DT, S_MUL1, S_MUL2, S_CHK, S_UPD,
// S_RF, S_DIV, S_CLAMP and S_DONE; S_DIV is a one-bit-per-cycle restoring divider over
// NUM_W = 30 + clog2(AVG_WINDOW + 1) bits (35 at default window). Other bytes go from
// S_DT to S_DONE, rejected clocks from S_CHK, rate zero from S_RF. One item per pass.
// Reset: asynchronous, clears queue, window, transport and clock state; tempo 120 BPM,
// sample rate 48000, jitter factor 2.0. The interval ring is not cleared.
`default_nettype none
module midi_clock_tempo_tracker_unit #(
    parameter int AVG_WINDOW = mctt_pkg::AVG_WINDOW_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_index,
    input  wire logic [mctt_pkg::RATE_W-1:0]   cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // status_byte[7:0], block_start[55:8], sample_offset[71:56]
    input  wire logic [mctt_pkg::IN_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // transport_running[0], tempo_bpm_q8[18:1], tempo_updated[19], zero[23:20]
    output logic      [mctt_pkg::OUT_W-1:0]    m_tdata
);

    logic               q_valid;
    logic               q_pop;
    mctt_pkg::q_entry_t q_entry;

    mctt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_entry  (q_entry)
    );

    mctt_back #(
        .AVG_WINDOW (AVG_WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_entry   (q_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire
